@@ hdl/tgr_pkg.sv @@
// shared types, codes and helpers of the touch gesture recogniser
// no dependencies; used by tgr_scan, tgr_mul, tgr_root and touch_gesture_recognizer
package tgr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAV_HORIZ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NAV_VERT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_START = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FLOOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CEIL  = 3'd7;

    // item kinds
    localparam logic [1:0] FN_POINT  = 2'd0;
    localparam logic [1:0] FN_EMPTY  = 2'd1;
    localparam logic [1:0] FN_CANCEL = 2'd2;

    // gesture modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_SINGLE  = 3'd1;
    localparam logic [2:0] M_SWIPE   = 3'd2;
    localparam logic [2:0] M_LONG    = 3'd3;
    localparam logic [2:0] M_DRAG    = 3'd4;
    localparam logic [2:0] M_TWOCAND = 3'd5;
    localparam logic [2:0] M_ZOOM    = 3'd6;
    localparam logic [2:0] M_CANCEL  = 3'd7;

    // actions
    localparam logic [2:0] A_NONE    = 3'd0;
    localparam logic [2:0] A_BEGIN   = 3'd1;
    localparam logic [2:0] A_UPDATE  = 3'd2;
    localparam logic [2:0] A_END     = 3'd3;
    localparam logic [2:0] A_BACK    = 3'd4;
    localparam logic [2:0] A_FORWARD = 3'd5;
    localparam logic [2:0] A_CANCEL  = 3'd6;

    // gesture flag bits
    localparam int FL_ELIG  = 0;
    localparam int FL_HORIZ = 1;
    localparam int FL_NAV   = 2;
    localparam int FL_AWAIT = 3;

    // frame reduction found bits
    localparam int SF_FIRST     = 0;
    localparam int SF_NEXT      = 1;
    localparam int SF_PRIM      = 2;
    localparam int SF_PRIMPRESS = 3;
    localparam int SF_OTHER     = 4;

    // frame reduction point slots
    localparam int SP_FIRST = 0;
    localparam int SP_NEXT  = 1;
    localparam int SP_PRIM  = 2;
    localparam int SP_OTHER = 3;

    localparam logic [15:0] ONE_Q12   = 16'd4096;
    localparam logic [32:0] SLOP_SQ   = 33'd4096;  // 64 squared

    typedef struct packed {
        logic [4:0]        found;
        logic [7:0]        id;
        logic [3:0][15:0]  x;
        logic [3:0][15:0]  y;
    } t_scan;

    // |b - a| of two signed 16 bit coordinates
    function automatic logic [15:0] f_absdiff(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        logic [16:0] nd;
        d  = {b[15], b} - {a[15], a};
        nd = 17'd0 - d;
        return d[16] ? nd[15:0] : d[15:0];
    endfunction

    // b - a > 0 for signed 16 bit coordinates
    function automatic logic f_ahead(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        d = {b[15], b} - {a[15], a};
        return !d[16] && (d != 17'd0);
    endfunction

endpackage

@@ hdl/tgr_if.sv @@
// channel interfaces of the touch gesture recogniser: contact points in, results out
// no dependencies
interface tgr_pt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  contact_id;
    logic        is_pressed;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] time_ms;
    logic        frame_last;

    modport source (output valid, func, contact_id, is_pressed, pos_x, pos_y, time_ms,
                    frame_last, input ready);
    modport sink (input valid, func, contact_id, is_pressed, pos_x, pos_y, time_ms,
                  frame_last, output ready);
endinterface

interface tgr_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [2:0]  gesture_state;
    logic [15:0] zoom_factor;
    logic        suppress_page_touch;
    logic        menu_handled;

    modport source (output valid, action, gesture_state, zoom_factor, suppress_page_touch,
                    menu_handled, input ready);
    modport sink (input valid, action, gesture_state, zoom_factor, suppress_page_touch,
                  menu_handled, output ready);
endinterface

@@ hdl/tgr_scan.sv @@
// frame reduction: keeps first, next and other pressed points and the primary point of a frame
// depends on tgr_pkg
module tgr_scan
    import tgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_upd,
    input  logic        i_clr,
    input  logic [7:0]  i_primary,
    input  logic [7:0]  i_id,
    input  logic        i_pressed,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    output t_scan       o_scan
);

    t_scan r_scan;
    t_scan n_scan;

    always_comb begin
        n_scan = r_scan;
        if (i_clr) begin
            n_scan.found = '0;
            n_scan.id    = '0;
        end else if (i_upd) begin
            if (i_pressed) begin
                if (!r_scan.found[SF_FIRST]) begin
                    n_scan.found[SF_FIRST] = 1'b1;
                    n_scan.id              = i_id;
                    n_scan.x[SP_FIRST]     = i_x;
                    n_scan.y[SP_FIRST]     = i_y;
                end else if (!r_scan.found[SF_NEXT]) begin
                    n_scan.found[SF_NEXT] = 1'b1;
                    n_scan.x[SP_NEXT]     = i_x;
                    n_scan.y[SP_NEXT]     = i_y;
                end
            end
            if (i_id == i_primary && !r_scan.found[SF_PRIM]) begin
                n_scan.found[SF_PRIM]      = 1'b1;
                n_scan.found[SF_PRIMPRESS] = i_pressed;
                n_scan.x[SP_PRIM]          = i_x;
                n_scan.y[SP_PRIM]          = i_y;
            end
            if (i_pressed && i_id != i_primary && !r_scan.found[SF_OTHER]) begin
                n_scan.found[SF_OTHER] = 1'b1;
                n_scan.x[SP_OTHER]     = i_x;
                n_scan.y[SP_OTHER]     = i_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan.x <= n_scan.x;
        r_scan.y <= n_scan.y;
        if (!i_rst_n) begin
            r_scan.found <= '0;
            r_scan.id    <= '0;
        end else begin
            r_scan.found <= n_scan.found;
            r_scan.id    <= n_scan.id;
        end
    end

    assign o_scan = r_scan;

endmodule

@@ hdl/tgr_mul.sv @@
// shared 32 x 32 multiplier with registered product
// depends on tgr_pkg
module tgr_mul
    import tgr_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/tgr_root.sv @@
// zoom root unit: floor(sqrt((num << 24) / den)), saturated to 16 bits
// one quotient bit per cycle, then one root bit per cycle; depends on tgr_pkg
module tgr_root
    import tgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [15:0] o_root
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_SQRT = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_den, n_den;
    logic [31:0] r_low, n_low;
    logic [31:0] r_q, n_q;
    logic [31:0] r_n, n_n;
    logic [31:0] r_res, n_res;
    logic [31:0] r_bit, n_bit;
    logic        r_done, n_done;

    logic [33:0] rem_sh;
    logic [33:0] rem_sub;
    logic [31:0] q_next;
    logic [32:0] sq_sum;
    logic [40:0] den_sh;

    assign rem_sh  = {r_rem, r_low[31]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_next  = {r_q[30:0], !rem_sub[33]};
    assign sq_sum  = {1'b0, r_res} + {1'b0, r_bit};
    assign den_sh  = {i_den, 8'd0};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_low   = r_low;
        n_q     = r_q;
        n_n     = r_n;
        n_res   = r_res;
        n_bit   = r_bit;
        n_done  = 1'b0;
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_den = i_den;
                    n_rem = {8'd0, i_num[32:8]};
                    n_low = {i_num[7:0], 24'd0};
                    n_q   = '0;
                    n_res = '0;
                    n_bit = 32'h4000_0000;
                    // quotient of 2^32 or more: every root above the ceiling acts alike
                    if ({8'd0, i_num} >= den_sh) begin
                        n_n     = '1;
                        n_cnt   = 5'd15;
                        n_phase = P_SQRT;
                    end else begin
                        n_cnt   = 5'd31;
                        n_phase = P_DIV;
                    end
                end
            end
            P_DIV: begin
                n_rem = rem_sub[33] ? rem_sh[32:0] : rem_sub[32:0];
                n_low = {r_low[30:0], 1'b0};
                n_q   = q_next;
                if (r_cnt == 5'd0) begin
                    n_n     = q_next;
                    n_cnt   = 5'd15;
                    n_phase = P_SQRT;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            P_SQRT: begin
                if ({1'b0, r_n} >= sq_sum) begin
                    n_n   = r_n - sq_sum[31:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_cnt == 5'd0) begin
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
        r_q   <= n_q;
        r_n   <= n_n;
        r_res <= n_res;
        r_bit <= n_bit;
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[15:0];

endmodule

@@ hdl/touch_gesture_recognizer.sv @@
// top level of the touch gesture recogniser: sequencer, gesture state and result register
// depends on tgr_pkg, tgr_if, tgr_scan, tgr_mul and tgr_root
//
//  port     | dir | kind        | carries
//  ---------+-----+-------------+-------------------------------------------------
//  i_pt     | in  | valid/ready | one contact point, empty frame or cancel request
//  o_res    | out | valid/ready | action, gesture state, zoom factor, flags
//  i_cfg_*  | in  | write only  | thresholds and zoom clamp, index 0..7
//
//  a point that does not end a frame is taken into the frame reduction and gives no transfer
//  a frame end keeps the sequencer busy after its transfer, a zoom update longer: the
//  shared multiplier issues one square or product per cycle, and the root unit first
//  divides, then takes the root, skipping the divide when the quotient saturates
//  i_pt.ready is low while a frame end or cancel request is being worked on, and
//  also while the previous result still waits; a finished result waits in the output
//  register and the next point is taken meanwhile
//  reset is synchronous and returns to idle with the state and configuration registers at their defaults
module touch_gesture_recognizer
    import tgr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tgr_pt_if.sink                i_pt,
    tgr_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer steps
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECIDE = 5'd1;
    localparam logic [4:0] S_SQX    = 5'd2;
    localparam logic [4:0] S_SQY    = 5'd3;
    localparam logic [4:0] S_SQS    = 5'd4;
    localparam logic [4:0] S_TWO    = 5'd5;
    localparam logic [4:0] S_S2     = 5'd6;
    localparam logic [4:0] S_RG_T   = 5'd7;
    localparam logic [4:0] S_RG_P   = 5'd8;
    localparam logic [4:0] S_RG_C   = 5'd9;
    localparam logic [4:0] S_ZST    = 5'd10;
    localparam logic [4:0] S_ZWT    = 5'd11;
    localparam logic [4:0] S_SWM    = 5'd12;
    localparam logic [4:0] S_SW     = 5'd13;
    localparam logic [4:0] S_DRM    = 5'd14;
    localparam logic [4:0] S_DRC    = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    // configuration
    logic [13:0] r_swipe_start, r_drag_start, r_nav_horiz, r_nav_vert, r_scale_start;
    logic [15:0] r_long_time, r_scale_floor, r_scale_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swipe_start <= 14'd160;
            r_long_time   <= 16'd500;
            r_drag_start  <= 14'd128;
            r_nav_horiz   <= 14'd1280;
            r_nav_vert    <= 14'd640;
            r_scale_start <= 14'd160;
            r_scale_floor <= 16'd2048;
            r_scale_ceil  <= 16'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SWIPE_START: r_swipe_start <= i_cfg_data[13:0];
                CFG_LONG_TIME:   r_long_time   <= i_cfg_data;
                CFG_DRAG_START:  r_drag_start  <= i_cfg_data[13:0];
                CFG_NAV_HORIZ:   r_nav_horiz   <= i_cfg_data[13:0];
                CFG_NAV_VERT:    r_nav_vert    <= i_cfg_data[13:0];
                CFG_SCALE_START: r_scale_start <= i_cfg_data[13:0];
                CFG_SCALE_FLOOR: r_scale_floor <= i_cfg_data;
                CFG_SCALE_CEIL:  r_scale_ceil  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // gesture state
    logic [4:0]  r_state, n_state;
    logic [4:0]  r_ret, n_ret;
    logic [2:0]  r_mode, n_mode;
    logic [7:0]  r_primary, n_primary;
    logic [15:0] r_start_x, n_start_x, r_start_y, n_start_y;
    logic [15:0] r_recent_x, n_recent_x, r_recent_y, n_recent_y;
    logic [15:0] r_hold_x, n_hold_x, r_hold_y, n_hold_y;
    logic [31:0] r_start_time, n_start_time;
    logic [32:0] r_init, n_init;
    logic [15:0] r_scale, n_scale;
    logic [3:0]  r_flags, n_flags;

    // working registers of one frame end
    logic [31:0] r_time, n_time;
    logic [15:0] r_px, n_px, r_py, n_py;
    logic [15:0] r_ax, n_ax, r_ay, n_ay;
    logic [15:0] r_adx, n_adx, r_ady, n_ady;
    logic        r_dxpos, n_dxpos;
    logic [32:0] r_acc, n_acc;
    logic [32:0] r_mv2, n_mv2;
    logic [32:0] r_d2, n_d2;
    logic [27:0] r_s2, n_s2;
    logic [63:0] r_tt, n_tt;
    logic        r_dir, n_dir;
    logic [2:0]  r_act, n_act;

    // result register
    logic        r_ovalid;
    logic [2:0]  r_oact, r_ostate;
    logic [15:0] r_ozoom;
    logic        out_load;

    // shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic        root_start, root_done;
    logic [15:0] root_val;
    logic        scan_upd, scan_clr;
    t_scan       scan;
    logic        pt_acc;

    tgr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    tgr_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_num   (r_d2),
        .i_den   (r_init),
        .o_done  (root_done),
        .o_root  (root_val)
    );

    tgr_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (scan_upd),
        .i_clr     (scan_clr),
        .i_primary (r_primary),
        .i_id      (i_pt.contact_id),
        .i_pressed (i_pt.is_pressed),
        .i_x       (i_pt.pos_x),
        .i_y       (i_pt.pos_y),
        .o_scan    (scan)
    );

    assign i_pt.ready = (r_state == S_IDLE);
    assign pt_acc     = i_pt.valid && i_pt.ready;

    // frame end selection: on a touch begin the first pressed point is the primary
    logic        sel_began, sel_pf, sel_pp, sel_sf;
    logic [2:0]  sel_mode;
    logic [15:0] sel_px, sel_py, sel_sx, sel_sy, sel_stx, sel_sty;

    assign sel_began = (r_mode == M_IDLE) || (r_mode == M_CANCEL);
    assign sel_mode  = sel_began ? M_SINGLE : r_mode;
    assign sel_pf    = sel_began || scan.found[SF_PRIM];
    assign sel_pp    = sel_began || scan.found[SF_PRIMPRESS];
    assign sel_sf    = sel_began ? scan.found[SF_NEXT] : scan.found[SF_OTHER];
    assign sel_px    = sel_began ? scan.x[SP_FIRST] : scan.x[SP_PRIM];
    assign sel_py    = sel_began ? scan.y[SP_FIRST] : scan.y[SP_PRIM];
    assign sel_sx    = sel_began ? scan.x[SP_NEXT] : scan.x[SP_OTHER];
    assign sel_sy    = sel_began ? scan.y[SP_NEXT] : scan.y[SP_OTHER];
    assign sel_stx   = sel_began ? sel_px : r_start_x;
    assign sel_sty   = sel_began ? sel_py : r_start_y;

    // spread test operands: direction 0 grows, direction 1 shrinks
    logic [32:0] rg_a2, rg_b2;
    logic [33:0] rg_sum, rg_t;
    logic [61:0] rg_p2;
    logic        rg_pass;

    assign rg_a2  = r_dir ? r_init : r_d2;
    assign rg_b2  = r_dir ? r_d2 : r_init;
    assign rg_sum = {1'b0, rg_b2} + {6'd0, r_s2};
    assign rg_t   = {1'b0, rg_a2} - rg_sum;
    assign rg_p2  = {1'b0, mul_prod[60:0]} + (rg_b2[32] ? {2'd0, r_s2, 32'd0} : 62'd0);
    assign rg_pass = (r_tt >= {rg_p2, 2'b00});

    // single finger step values
    logic [2:0]  sw_mode;
    logic [3:0]  sw_flags;
    logic [31:0] elapsed;

    assign elapsed = r_time - r_start_time;

    always_comb begin
        sw_mode  = r_mode;
        sw_flags = r_flags;
        if (r_mode == M_SINGLE) begin
            if (r_mv2 >= {1'b0, mul_prod[31:0]}) begin
                sw_mode            = M_SWIPE;
                sw_flags[FL_ELIG]  = 1'b0;
                sw_flags[FL_HORIZ] = (r_adx > r_ady);
            end else if (r_mv2 >= SLOP_SQ) begin
                sw_flags[FL_ELIG] = 1'b0;
            end
            if (sw_mode == M_SINGLE && sw_flags[FL_ELIG] && elapsed >= {16'd0, r_long_time}) begin
                sw_mode = M_LONG;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_mode       = r_mode;
        n_primary    = r_primary;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        n_recent_x   = r_recent_x;
        n_recent_y   = r_recent_y;
        n_hold_x     = r_hold_x;
        n_hold_y     = r_hold_y;
        n_start_time = r_start_time;
        n_init       = r_init;
        n_scale      = r_scale;
        n_flags      = r_flags;
        n_time       = r_time;
        n_px         = r_px;
        n_py         = r_py;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_adx        = r_adx;
        n_ady        = r_ady;
        n_dxpos      = r_dxpos;
        n_acc        = r_acc;
        n_mv2        = r_mv2;
        n_d2         = r_d2;
        n_s2         = r_s2;
        n_tt         = r_tt;
        n_dir        = r_dir;
        n_act        = r_act;
        mul_a        = '0;
        mul_b        = '0;
        root_start   = 1'b0;
        scan_upd     = 1'b0;
        scan_clr     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (pt_acc) begin
                    n_time = i_pt.time_ms;
                    case (i_pt.func)
                        FN_POINT: begin
                            scan_upd = 1'b1;
                            if (i_pt.frame_last) begin
                                n_state = S_DECIDE;
                            end
                        end
                        FN_EMPTY: begin
                            scan_clr = 1'b1;
                            n_state  = S_DECIDE;
                        end
                        FN_CANCEL: begin
                            scan_clr = 1'b1;
                            if (r_mode == M_IDLE || r_mode == M_CANCEL) begin
                                n_act = A_NONE;
                            end else begin
                                n_mode = M_CANCEL;
                                n_act  = A_CANCEL;
                            end
                            n_state = S_OUT;
                        end
                        default: ;  // undefined kind, dropped
                    endcase
                end
            end

            S_DECIDE: begin
                scan_clr = 1'b1;
                n_act    = A_NONE;
                if (r_mode == M_CANCEL && r_flags[FL_AWAIT]) begin
                    // waiting for all fingers up after a zero spread
                    if (!scan.found[SF_FIRST]) begin
                        n_mode    = M_IDLE;
                        n_primary = '0;
                        n_init    = '0;
                        n_scale   = ONE_Q12;
                        n_flags   = '0;
                    end
                    n_state = S_OUT;
                end else if (sel_began && !scan.found[SF_FIRST]) begin
                    n_state = S_OUT;
                end else begin
                    if (sel_began) begin
                        n_mode       = M_SINGLE;
                        n_primary    = scan.id;
                        n_start_x    = sel_px;
                        n_start_y    = sel_py;
                        n_recent_x   = sel_px;
                        n_recent_y   = sel_py;
                        n_hold_x     = sel_px;
                        n_hold_y     = sel_py;
                        n_start_time = r_time;
                        n_init       = '0;
                        n_scale      = ONE_Q12;
                        n_flags      = 4'd0;
                        n_flags[FL_ELIG] = 1'b1;
                    end
                    n_px = sel_px;
                    n_py = sel_py;
                    if (!sel_pf || !sel_pp) begin
                        if (sel_pf) begin
                            // primary lifted
                            n_act     = (sel_mode == M_DRAG) ? A_END : A_NONE;
                            n_mode    = M_IDLE;
                            n_primary = '0;
                            n_init    = '0;
                            n_scale   = ONE_Q12;
                            n_flags   = '0;
                        end else begin
                            n_mode = M_CANCEL;
                            n_act  = A_CANCEL;
                        end
                        n_state = S_OUT;
                    end else if (sel_sf) begin
                        n_ax    = f_absdiff(sel_px, sel_sx);
                        n_ay    = f_absdiff(sel_py, sel_sy);
                        n_ret   = S_TWO;
                        n_state = S_SQX;
                    end else if (sel_mode == M_TWOCAND || sel_mode == M_ZOOM) begin
                        n_mode  = M_CANCEL;
                        n_act   = A_CANCEL;
                        n_state = S_OUT;
                    end else begin
                        n_ax    = f_absdiff(sel_stx, sel_px);
                        n_ay    = f_absdiff(sel_sty, sel_py);
                        n_adx   = f_absdiff(sel_stx, sel_px);
                        n_ady   = f_absdiff(sel_sty, sel_py);
                        n_dxpos = f_ahead(sel_stx, sel_px);
                        n_ret   = S_SWM;
                        n_state = S_SQX;
                    end
                end
            end

            // sum of squares of r_ax and r_ay into r_acc
            S_SQX: begin
                mul_a   = {16'd0, r_ax};
                mul_b   = {16'd0, r_ax};
                n_state = S_SQY;
            end
            S_SQY: begin
                mul_a   = {16'd0, r_ay};
                mul_b   = {16'd0, r_ay};
                n_acc   = {1'b0, mul_prod[31:0]};
                n_state = S_SQS;
            end
            S_SQS: begin
                n_acc   = r_acc + {1'b0, mul_prod[31:0]};
                n_state = r_ret;
            end

            S_TWO: begin
                n_d2 = r_acc;
                if (r_mode != M_TWOCAND && r_mode != M_ZOOM) begin
                    // second finger arrives: record the initial spread
                    n_init  = r_acc;
                    n_scale = ONE_Q12;
                    n_flags = '0;
                    if (r_acc == 33'd0) begin
                        n_flags[FL_AWAIT] = 1'b1;
                        n_mode            = M_CANCEL;
                        n_act             = A_CANCEL;
                    end else begin
                        n_mode = M_TWOCAND;
                        n_act  = A_NONE;
                    end
                    n_state = S_OUT;
                end else if (r_mode == M_TWOCAND) begin
                    mul_a   = {18'd0, r_scale_start};
                    mul_b   = {18'd0, r_scale_start};
                    n_state = S_S2;
                end else begin
                    n_state = S_ZST;
                end
            end
            S_S2: begin
                n_s2    = mul_prod[27:0];
                n_dir   = 1'b0;
                n_state = S_RG_T;
            end
            // exact test sqrt(a2) >= s + sqrt(b2)
            S_RG_T: begin
                if (rg_t[33]) begin
                    if (r_dir) begin
                        n_act   = A_NONE;
                        n_state = S_OUT;
                    end else begin
                        n_dir = 1'b1;
                    end
                end else if (rg_t[32]) begin
                    n_mode  = M_ZOOM;
                    n_state = S_ZST;
                end else begin
                    mul_a   = rg_t[31:0];
                    mul_b   = rg_t[31:0];
                    n_state = S_RG_P;
                end
            end
            S_RG_P: begin
                n_tt    = mul_prod;
                mul_a   = {4'd0, r_s2};
                mul_b   = rg_b2[31:0];
                n_state = S_RG_C;
            end
            S_RG_C: begin
                if (rg_pass) begin
                    n_mode  = M_ZOOM;
                    n_state = S_ZST;
                end else if (r_dir) begin
                    n_act   = A_NONE;
                    n_state = S_OUT;
                end else begin
                    n_dir   = 1'b1;
                    n_state = S_RG_T;
                end
            end
            S_ZST: begin
                n_act = A_NONE;
                if (r_init == 33'd0) begin
                    n_state = S_OUT;
                end else begin
                    root_start = 1'b1;
                    n_state    = S_ZWT;
                end
            end
            S_ZWT: begin
                if (root_done) begin
                    // floor test wins over the ceiling
                    if (root_val < r_scale_floor) begin
                        n_scale = r_scale_floor;
                    end else if (root_val > r_scale_ceil) begin
                        n_scale = r_scale_ceil;
                    end else begin
                        n_scale = root_val;
                    end
                    n_state = S_OUT;
                end
            end

            // single finger: movement from start against the swipe radius
            S_SWM: begin
                n_mv2   = r_acc;
                mul_a   = {18'd0, r_swipe_start};
                mul_b   = {18'd0, r_swipe_start};
                n_state = S_SW;
            end
            S_SW: begin
                n_mode  = sw_mode;
                n_flags = sw_flags;
                n_act   = A_NONE;
                n_state = S_OUT;
                if (sw_mode == M_LONG) begin
                    if (r_mode == M_SINGLE) begin
                        n_hold_x = r_px;
                        n_hold_y = r_py;
                        n_ax     = '0;
                        n_ay     = '0;
                    end else begin
                        n_ax = f_absdiff(r_hold_x, r_px);
                        n_ay = f_absdiff(r_hold_y, r_py);
                    end
                    n_ret   = S_DRM;
                    n_state = S_SQX;
                end else if (sw_mode == M_DRAG) begin
                    n_act      = (r_px != r_recent_x || r_py != r_recent_y) ? A_UPDATE : A_NONE;
                    n_recent_x = r_px;
                    n_recent_y = r_py;
                end else if (sw_mode == M_SWIPE && !sw_flags[FL_NAV] && sw_flags[FL_HORIZ] &&
                             r_ady < {2'd0, r_nav_vert} && r_adx >= {2'd0, r_nav_horiz}) begin
                    n_flags[FL_NAV] = 1'b1;
                    n_act           = r_dxpos ? A_BACK : A_FORWARD;
                end else begin
                    n_recent_x = r_px;
                    n_recent_y = r_py;
                end
            end
            // long press: movement from hold point against the drag radius
            S_DRM: begin
                n_mv2   = r_acc;
                mul_a   = {18'd0, r_drag_start};
                mul_b   = {18'd0, r_drag_start};
                n_state = S_DRC;
            end
            S_DRC: begin
                n_recent_x = r_px;
                n_recent_y = r_py;
                if (r_mv2 >= {1'b0, mul_prod[31:0]}) begin
                    n_mode = M_DRAG;
                    n_act  = A_BEGIN;
                end else begin
                    n_act = A_NONE;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ret        <= n_ret;
        r_start_x    <= n_start_x;
        r_start_y    <= n_start_y;
        r_recent_x   <= n_recent_x;
        r_recent_y   <= n_recent_y;
        r_hold_x     <= n_hold_x;
        r_hold_y     <= n_hold_y;
        r_start_time <= n_start_time;
        r_time       <= n_time;
        r_px         <= n_px;
        r_py         <= n_py;
        r_ax         <= n_ax;
        r_ay         <= n_ay;
        r_adx        <= n_adx;
        r_ady        <= n_ady;
        r_dxpos      <= n_dxpos;
        r_acc        <= n_acc;
        r_mv2        <= n_mv2;
        r_d2         <= n_d2;
        r_s2         <= n_s2;
        r_tt         <= n_tt;
        r_dir        <= n_dir;
        r_act        <= n_act;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_IDLE;
            r_primary <= '0;
            r_init    <= '0;
            r_scale   <= ONE_Q12;
            r_flags   <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_recent_x <= '0;
            r_recent_y <= '0;
            r_hold_x  <= '0;
            r_hold_y  <= '0;
            r_start_time <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_primary <= n_primary;
            r_init    <= n_init;
            r_scale   <= n_scale;
            r_flags   <= n_flags;
        end
    end

    // output register: loaded as the sequencer leaves its final step
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oact   <= r_act;
            r_ostate <= r_mode;
            r_ozoom  <= r_scale;
        end
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_res.valid               = r_ovalid;
    assign o_res.action              = r_oact;
    assign o_res.gesture_state       = r_ostate;
    assign o_res.zoom_factor         = r_ozoom;
    assign o_res.suppress_page_touch = (r_oact == A_BACK) || (r_oact == A_FORWARD) ||
                                       (r_oact == A_CANCEL);
    assign o_res.menu_handled        = (r_oact != A_NONE);

    // a finished frame end always leaves a result waiting
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_ovalid)
        else $error("result not registered after frame end");

    // the await flag only lives in the cancelled mode
    a_await_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[FL_AWAIT] |-> (r_mode == M_CANCEL))
        else $error("await flag outside cancelled mode");

    // the root unit reports only while the sequencer waits for it
    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> (r_state == S_ZWT))
        else $error("root result with nobody waiting");

    // a frame end leaves an empty reduction behind
    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (scan.found == 5'd0))
        else $error("frame reduction not cleared");

endmodule
